// ----- rtl/assert_macros.svh -----
// assertion helpers for the odometry checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");

`define CHK_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");

`endif

// ----- rtl/poi_pkg.sv -----
package poi_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] lin_vel_x;
    logic [31:0] lin_vel_y;
    logic [31:0] ang_vel_z;
    logic [15:0] interval;
    logic [47:0] pose_x_in;
    logic [47:0] pose_y_in;
    logic [31:0] heading_in;
  } poi_in_t;

  typedef struct packed {
    logic [47:0] pose_x;
    logic [47:0] pose_y;
    logic [31:0] heading;
  } poi_out_t;

  localparam logic CMD_INTEGRATE = 1'b0;
  localparam logic CMD_SET_POSE  = 1'b1;
  localparam logic [63:0] GAIN_Q32 = 64'h9B74EDA8;

  function automatic logic [31:0] arc_angle(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/planar_odometry_integrator_top.sv -----
// set-pose goes from IDLE straight to UPD; integrate passes WDT, ROT, M0, M1, M2, M3, SUM, D0, D1, UPD
// a new transaction is taken only once the sequencer is back in IDLE
// a waiting result is held while the sequencer waits in UPD; in_stall is high while the sequencer is busy
// the CORDIC stage and one shared 33x33 multiplier run under a small sequencer
// rst_n synchronous active low: pose zero, method euler, sequencer idle, output empty
module planar_odometry_integrator_top #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  poi_pkg::poi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output poi_pkg::poi_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import poi_pkg::*;

  localparam int CW = FRACTION_BITS + 3;
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [63:0] X0_64 =
    (GAIN_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
  localparam logic signed [CW-1:0] X0 = X0_64[CW-1:0];

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WDT  = 4'd1;
  localparam logic [3:0] S_ROT  = 4'd2;
  localparam logic [3:0] S_M0   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_D0   = 4'd8;
  localparam logic [3:0] S_D1   = 4'd9;
  localparam logic [3:0] S_UPD  = 4'd10;

  logic [3:0]  state_r;
  logic [SW-1:0] step_r;
  logic        method_r;
  logic [47:0] px_r, py_r;
  logic [31:0] hd_r;
  logic signed [31:0] vx_r, vy_r, w_r;
  logic [15:0] dt_r;
  logic [31:0] turn_r;
  logic        flip_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [32:0]   cz_r;
  logic signed [CW+32:0] pa_r, pb_r;
  logic signed [47:0]   wx_r, wy_r, dx_r;
  logic        out_valid_r;
  poi_out_t    out_r;
  logic        out_free;

  // shared multiplier operands
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_WDT: begin ma = 33'(w_r);  mb = {17'd0, dt_r}; end
      S_M1:  begin ma = 33'(vx_r); mb = 33'(cx_r); end
      S_M2:  begin ma = 33'(vy_r); mb = 33'(cy_r); end
      S_M3:  begin ma = 33'(vx_r); mb = 33'(cy_r); end
      S_SUM: begin ma = 33'(vy_r); mb = 33'(cx_r); end
      S_D0:  begin ma = wx_r[32:0]; mb = {17'd0, dt_r}; end
      S_D1:  begin ma = wy_r[32:0]; mb = {17'd0, dt_r}; end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb;
  end

  // rotation angle is formed while w*dt is on the multiplier output
  logic [31:0] rot_ang;
  always_comb begin
    rot_ang = hd_r;
    if (method_r) rot_ang = hd_r + mp[48:17];
  end

  // middle two quadrants are moved by a half turn and negated at the end
  logic [31:0] seed;
  assign seed = (rot_ang[31:30] == 2'b01 || rot_ang[31:30] == 2'b10) ?
                {~rot_ang[31], rot_ang[30:0]} : rot_ang;

  logic signed [CW-1:0] xs, ys;
  logic signed [32:0] arc;
  assign xs  = cx_r >>> step_r;
  assign ys  = cy_r >>> step_r;
  assign arc = {1'b0, arc_angle(5'(step_r))};

  logic signed [CW+32:0] sum_x, sum_y;
  assign sum_x = pa_r - pb_r;
  assign sum_y = pa_r + pb_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      method_r    <= 1'b0;
      out_valid_r <= 1'b0;
      px_r <= '0; py_r <= '0; hd_r <= '0;
      step_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) method_r <= cfg_data;
      if (state_r == S_UPD && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            vx_r <= in_data.lin_vel_x;
            vy_r <= in_data.lin_vel_y;
            w_r  <= in_data.ang_vel_z;
            dt_r <= in_data.interval;
            if (in_data.cmd == CMD_SET_POSE) begin
              px_r <= in_data.pose_x_in;
              py_r <= in_data.pose_y_in;
              hd_r <= in_data.heading_in;
              state_r <= S_UPD;
            end else begin
              state_r <= S_WDT;
            end
          end
        end
        S_WDT: begin
          turn_r  <= mp[47:16];
          cx_r    <= X0;
          cy_r    <= '0;
          cz_r    <= {seed[31], seed};
          flip_r  <= (rot_ang[31:30] == 2'b01) || (rot_ang[31:30] == 2'b10);
          state_r <= S_ROT;
          step_r  <= '0;
        end
        S_ROT: begin
          if (step_r == SW'(CORDIC_STEPS - 1)) state_r <= S_M0;
          step_r <= step_r + 1'b1;
          if (cz_r >= 0) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - arc;
          end else begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + arc;
          end
        end
        S_M0: begin
          if (flip_r) begin cx_r <= -cx_r; cy_r <= -cy_r; end
          state_r <= S_M1;
        end
        S_M1: begin pa_r <= (CW+33)'(mp); state_r <= S_M2; end
        S_M2: begin pb_r <= (CW+33)'(mp); state_r <= S_M3; end
        S_M3: begin
          wx_r <= 48'(sum_x >>> FRACTION_BITS);
          pa_r <= (CW+33)'(mp);
          state_r <= S_SUM;
        end
        S_SUM: begin
          pb_r <= (CW+33)'(mp);
          state_r <= S_D0;
        end
        S_D0: begin
          wy_r <= 48'(sum_y >>> FRACTION_BITS);
          dx_r <= 48'(mp >>> 16);
          state_r <= S_D1;
        end
        S_D1: begin
          state_r <= S_UPD;
          px_r <= px_r + dx_r;
          py_r <= py_r + 48'(mp >>> 16);
          hd_r <= hd_r + turn_r;
        end
        S_UPD: begin
          if (out_free) begin
            out_r <= '{px_r, py_r, hd_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r && !in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ----- rtl/poi_checker.sv -----
module poi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_valid,
  input logic cfg_ready
);
`include "assert_macros.svh"
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_IMPLY(a_cfg_quiet, clk, rst_n, cfg_ready, !out_valid)
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_IMPLY(a_cfg_idle, clk, rst_n, cfg_ready, !in_stall)
endmodule

bind planar_odometry_integrator_top poi_checker u_chk (.*);
